// ===== hdl/line_position_pid_steering_core_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the line-position PID steering core
// ---------------------------------------------------------------------------
`ifndef LINE_POSITION_PID_STEERING_CORE_ASSERT_SVH
`define LINE_POSITION_PID_STEERING_CORE_ASSERT_SVH

// same-cycle implication, sampled on clk, off during rst
`define LPPS_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lpps assertion failed");

// next-cycle implication
`define LPPS_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lpps assertion failed");

`endif

// ===== hdl/lpps_pkg.sv =====
// ---------------------------------------------------------------------------
// lpps_pkg
// Types, microcode codes and constant tables for the steering core.
// ---------------------------------------------------------------------------
package lpps_pkg;

  localparam int PC_W = 4;

  typedef enum logic [3:0] {
    OP_NOP  = 4'd0,
    OP_LOAD = 4'd1,
    OP_PID  = 4'd2,
    OP_DIV  = 4'd3,
    OP_MUL  = 4'd4,
    OP_SUM  = 4'd5,
    OP_MIX  = 4'd6,
    OP_STOP = 4'd7,
    OP_EMIT = 4'd8
  } op_t;

  typedef enum logic [2:0] {
    C_NEVER    = 3'd0,
    C_ALWAYS   = 3'd1,
    C_NO_IN    = 3'd2,
    C_NO_LINE  = 3'd3,
    C_DIV_RUN  = 3'd4,
    C_OUT_BUSY = 3'd5
  } cond_t;

  typedef struct packed {
    op_t              op;
    cond_t            cond;
    logic [PC_W-1:0]  target;
  } ucode_t;

  typedef struct packed {
    op_t op;
  } ctrl_t;

  typedef struct packed {
    logic in_fire;
    logic no_line;
    logic div_run;
    logic out_busy;
  } status_t;

  typedef struct packed {
    logic [12:0] setpoint;
    logic [3:0]  prop_gain;
    logic [11:0] deriv_gain_q10;
    logic [15:0] integral_divisor;
    logic [14:0] integral_reset_limit;
    logic [7:0]  max_speed;
  } cfg_t;

  // register indexes
  localparam logic [2:0] REG_SETPOINT  = 3'd0;
  localparam logic [2:0] REG_PROP_GAIN = 3'd1;
  localparam logic [2:0] REG_DERIV_GN  = 3'd2;
  localparam logic [2:0] REG_INT_DIV   = 3'd3;
  localparam logic [2:0] REG_INT_LIM   = 3'd4;
  localparam logic [2:0] REG_MAX_SPEED = 3'd5;

  // action codes
  localparam logic [1:0] ACT_TRACK      = 2'd0;
  localparam logic [1:0] ACT_SPIN_LEFT  = 2'd1;
  localparam logic [1:0] ACT_SPIN_RIGHT = 2'd2;
  localparam logic [1:0] ACT_STOP       = 2'd3;

  localparam int DIV_STEPS = 16;

  // centroid of lit sensors, weights 2..6 times 1000, floor divided by count
  localparam logic [12:0] POS_TABLE [32] = '{
    13'd0,    13'd2000, 13'd3000, 13'd2500, 13'd4000, 13'd3000, 13'd3500, 13'd3000,
    13'd5000, 13'd3500, 13'd4000, 13'd3333, 13'd4500, 13'd3666, 13'd4000, 13'd3500,
    13'd6000, 13'd4000, 13'd4500, 13'd3666, 13'd5000, 13'd4000, 13'd4333, 13'd3750,
    13'd5500, 13'd4333, 13'd4666, 13'd4000, 13'd5000, 13'd4250, 13'd4500, 13'd4000
  };

endpackage

// ===== hdl/lpps_seq.sv =====
// ---------------------------------------------------------------------------
// lpps_seq
// Microprogram ROM and step counter with conditional jumps.
// ---------------------------------------------------------------------------
module lpps_seq (
  input  logic              clk,
  input  logic              rst,
  input  lpps_pkg::status_t status,
  output lpps_pkg::ctrl_t   ctrl
);

  logic [lpps_pkg::PC_W-1:0] pc;
  logic [lpps_pkg::PC_W-1:0] pc_next;
  lpps_pkg::ucode_t          uw;
  logic                      jump;

  always_comb begin
    unique case (pc)
      4'd0:    uw = '{lpps_pkg::OP_LOAD, lpps_pkg::C_NO_IN,    4'd0};
      4'd1:    uw = '{lpps_pkg::OP_NOP,  lpps_pkg::C_NO_LINE,  4'd7};
      4'd2:    uw = '{lpps_pkg::OP_PID,  lpps_pkg::C_NEVER,    4'd0};
      4'd3:    uw = '{lpps_pkg::OP_DIV,  lpps_pkg::C_DIV_RUN,  4'd3};
      4'd4:    uw = '{lpps_pkg::OP_MUL,  lpps_pkg::C_NEVER,    4'd0};
      4'd5:    uw = '{lpps_pkg::OP_SUM,  lpps_pkg::C_NEVER,    4'd0};
      4'd6:    uw = '{lpps_pkg::OP_MIX,  lpps_pkg::C_ALWAYS,   4'd8};
      4'd7:    uw = '{lpps_pkg::OP_STOP, lpps_pkg::C_NEVER,    4'd0};
      4'd8:    uw = '{lpps_pkg::OP_EMIT, lpps_pkg::C_OUT_BUSY, 4'd8};
      default: uw = '{lpps_pkg::OP_NOP,  lpps_pkg::C_ALWAYS,   4'd0};
    endcase
  end

  always_comb begin
    unique case (uw.cond)
      lpps_pkg::C_NEVER:    jump = 1'b0;
      lpps_pkg::C_ALWAYS:   jump = 1'b1;
      lpps_pkg::C_NO_IN:    jump = !status.in_fire;
      lpps_pkg::C_NO_LINE:  jump = status.no_line;
      lpps_pkg::C_DIV_RUN:  jump = status.div_run;
      lpps_pkg::C_OUT_BUSY: jump = status.out_busy;
      default:              jump = 1'b0;
    endcase
    pc_next = jump ? uw.target : pc + 1'b1;
    ctrl.op = uw.op;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= '0;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

// ===== hdl/lpps_dp.sv =====
// ---------------------------------------------------------------------------
// lpps_dp
// PID datapath: centroid, error state, radix-2 divider, gains, mixer and
// output register.
// ---------------------------------------------------------------------------
module lpps_dp (
  input  logic             clk,
  input  logic             rst,
  input  lpps_pkg::ctrl_t  ctrl,
  input  lpps_pkg::cfg_t   cfg,
  input  logic             in_fire,
  input  logic [6:0]       in_data,
  input  logic             out_ready,
  output logic             out_valid,
  output logic [15:0]      out_data,
  output logic [1:0]       out_action,
  output logic             no_line,
  output logic             div_run,
  output logic             out_busy
);

  logic [4:0]         sensors;
  logic               left_armed;
  logic               right_armed;
  logic signed [15:0] last_error;
  logic signed [15:0] error_sum;
  logic signed [15:0] err;
  logic signed [16:0] deriv;
  logic               sum_neg;
  logic [15:0]        quo;
  logic [15:0]        rem;
  logic [3:0]         cnt;
  logic signed [16:0] iterm;
  logic [18:0]        dmag;
  logic               dneg;
  logic signed [20:0] prop;
  logic signed [21:0] corr;
  logic [7:0]         res_a;
  logic [7:0]         res_b;
  logic [1:0]         res_act;

  logic [12:0]        pos;
  logic signed [15:0] err_c;
  logic signed [16:0] sum17;
  logic signed [16:0] lim17;
  logic               sum_clr;
  logic signed [15:0] sum_new;
  logic [15:0]        sum_mag;
  logic signed [16:0] deriv_c;
  logic [16:0]        rem_sh;
  logic [16:0]        rem_sub;
  logic               fits;
  logic [16:0]        dmag_in;
  logic [28:0]        dprod;
  logic signed [20:0] prop_c;
  logic signed [16:0] iterm_c;
  logic signed [19:0] dterm;
  logic signed [21:0] corr_c;
  logic signed [21:0] ms22;
  logic signed [21:0] clip;
  logic signed [21:0] a_c;
  logic signed [21:0] b_c;
  logic               spin_l;
  logic               spin_r;

  assign no_line  = (sensors == 5'd0);
  assign div_run  = (cnt != 4'd0);
  assign out_busy = out_valid && !out_ready;

  always_comb begin
    pos     = lpps_pkg::POS_TABLE[sensors];
    err_c   = signed'({3'b000, pos}) - signed'({3'b000, cfg.setpoint});
    sum17   = {error_sum[15], error_sum};
    lim17   = signed'({2'b00, cfg.integral_reset_limit});
    sum_clr = (sum17 == lim17) || (sum17 == -lim17);
    sum_new = (sum_clr ? 16'sd0 : error_sum) + err_c;
    sum_mag = sum_new[15] ? (~sum_new + 16'd1) : sum_new;
    deriv_c = {err_c[15], err_c} - {last_error[15], last_error};

    rem_sh  = {rem, quo[15]};
    fits    = rem_sh >= {1'b0, cfg.integral_divisor};
    rem_sub = rem_sh - {1'b0, cfg.integral_divisor};

    dmag_in = deriv[16] ? (~deriv + 17'd1) : deriv;
    dprod   = 29'(dmag_in) * 29'(cfg.deriv_gain_q10);
    prop_c  = 21'(err) * signed'({17'd0, cfg.prop_gain});
    if (cfg.integral_divisor == 16'd0) begin
      iterm_c = '0;
    end else if (sum_neg) begin
      iterm_c = -signed'({1'b0, quo});
    end else begin
      iterm_c = signed'({1'b0, quo});
    end

    dterm  = dneg ? -signed'({1'b0, dmag}) : signed'({1'b0, dmag});
    corr_c = 22'(prop) + 22'(iterm) + 22'(dterm);

    ms22 = signed'({14'd0, cfg.max_speed});
    if (corr > ms22) begin
      clip = ms22;
    end else if (corr < -ms22) begin
      clip = -ms22;
    end else begin
      clip = corr;
    end
    if (clip < 0) begin
      a_c = ms22 + clip;
      b_c = ms22;
    end else begin
      a_c = ms22;
      b_c = ms22 - clip;
    end
    spin_l = sensors[0] && sensors[1] && sensors[2] && left_armed;
    spin_r = sensors[2] && sensors[3] && sensors[4] && right_armed;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      left_armed  <= 1'b0;
      right_armed <= 1'b0;
      last_error  <= '0;
      error_sum   <= '0;
      cnt         <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (out_valid && out_ready && ctrl.op != lpps_pkg::OP_EMIT) begin
        out_valid <= 1'b0;
      end
      unique case (ctrl.op)
        lpps_pkg::OP_LOAD: begin
          if (in_fire) begin
            sensors <= in_data[4:0];
            if (in_data[5] && in_data[6]) begin
              left_armed  <= 1'b0;
              right_armed <= 1'b0;
            end else if (in_data[5]) begin
              right_armed <= 1'b1;
              left_armed  <= 1'b0;
            end else if (in_data[6]) begin
              left_armed  <= 1'b1;
              right_armed <= 1'b0;
            end
          end
        end
        lpps_pkg::OP_PID: begin
          err        <= err_c;
          deriv      <= deriv_c;
          last_error <= err_c;
          error_sum  <= sum_new;
          sum_neg    <= sum_new[15];
          quo        <= sum_mag;
          rem        <= '0;
          cnt        <= 4'(lpps_pkg::DIV_STEPS - 1);
        end
        lpps_pkg::OP_DIV: begin
          if (fits) begin
            rem <= rem_sub[15:0];
            quo <= {quo[14:0], 1'b1};
          end else begin
            rem <= rem_sh[15:0];
            quo <= {quo[14:0], 1'b0};
          end
          cnt <= cnt - 4'd1;
        end
        lpps_pkg::OP_MUL: begin
          dmag  <= dprod[28:10];
          dneg  <= deriv[16];
          prop  <= prop_c;
          iterm <= iterm_c;
        end
        lpps_pkg::OP_SUM: begin
          corr <= corr_c;
        end
        lpps_pkg::OP_MIX: begin
          if (spin_l) begin
            res_a      <= cfg.max_speed;
            res_b      <= cfg.max_speed;
            res_act    <= lpps_pkg::ACT_SPIN_LEFT;
            left_armed <= 1'b0;
          end else if (spin_r) begin
            res_a       <= cfg.max_speed;
            res_b       <= cfg.max_speed;
            res_act     <= lpps_pkg::ACT_SPIN_RIGHT;
            right_armed <= 1'b0;
          end else begin
            res_a   <= a_c[7:0];
            res_b   <= b_c[7:0];
            res_act <= lpps_pkg::ACT_TRACK;
          end
        end
        lpps_pkg::OP_STOP: begin
          res_a   <= '0;
          res_b   <= '0;
          res_act <= lpps_pkg::ACT_STOP;
        end
        lpps_pkg::OP_EMIT: begin
          if (!out_busy) begin
            out_data   <= {res_b, res_a};
            out_action <= res_act;
            out_valid  <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== hdl/line_position_pid_steering_core.sv =====
// Requests are taken only in the load step, not until the last result is in
// the output register. While tracking, the PID, 16-step restoring divide for
// the integral term, multiply, sum and mix steps run; no lit sensor: stop step.
// A finished result waits in the output register while the next request
// is taken. Synchronous active-high reset: PID state, turn flags and
// handshakes cleared, registers back to their defaults.
// ---------------------------------------------------------------------------
// line_position_pid_steering_core
// Microcoded line-follower PID steering with APB register access.
// ---------------------------------------------------------------------------
`include "line_position_pid_steering_core_assert.svh"

module line_position_pid_steering_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [4:0] line_sensors, [5] right_marker, [6] left_marker
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [7:0] motor_a_duty, [15:8] motor_b_duty
  output logic [1:0]  m_tuser,   // [1:0] action
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  lpps_pkg::cfg_t    cfg;
  lpps_pkg::ctrl_t   ctrl;
  lpps_pkg::status_t status;
  logic              in_fire;
  logic              cfg_wr;
  logic              no_line;
  logic              div_run;
  logic              out_busy;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign s_tready = (ctrl.op == lpps_pkg::OP_LOAD);
  assign in_fire  = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.setpoint             <= 13'd4000;
      cfg.prop_gain            <= 4'd1;
      cfg.deriv_gain_q10       <= 12'd922;
      cfg.integral_divisor     <= 16'd10000;
      cfg.integral_reset_limit <= 15'd30000;
      cfg.max_speed            <= 8'd255;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        lpps_pkg::REG_SETPOINT:  cfg.setpoint             <= pwdata[12:0];
        lpps_pkg::REG_PROP_GAIN: cfg.prop_gain            <= pwdata[3:0];
        lpps_pkg::REG_DERIV_GN:  cfg.deriv_gain_q10       <= pwdata[11:0];
        lpps_pkg::REG_INT_DIV:   cfg.integral_divisor     <= pwdata[15:0];
        lpps_pkg::REG_INT_LIM:   cfg.integral_reset_limit <= pwdata[14:0];
        lpps_pkg::REG_MAX_SPEED: cfg.max_speed            <= pwdata[7:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      lpps_pkg::REG_SETPOINT:  prdata = {19'd0, cfg.setpoint};
      lpps_pkg::REG_PROP_GAIN: prdata = {28'd0, cfg.prop_gain};
      lpps_pkg::REG_DERIV_GN:  prdata = {20'd0, cfg.deriv_gain_q10};
      lpps_pkg::REG_INT_DIV:   prdata = {16'd0, cfg.integral_divisor};
      lpps_pkg::REG_INT_LIM:   prdata = {17'd0, cfg.integral_reset_limit};
      lpps_pkg::REG_MAX_SPEED: prdata = {24'd0, cfg.max_speed};
      default:                 prdata = '0;
    endcase
  end

  assign status = '{in_fire: in_fire, no_line: no_line, div_run: div_run,
                    out_busy: out_busy};

  lpps_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .ctrl   (ctrl)
  );

  lpps_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl),
    .cfg        (cfg),
    .in_fire    (in_fire),
    .in_data    (s_tdata[6:0]),
    .out_ready  (m_tready),
    .out_valid  (m_tvalid),
    .out_data   (m_tdata),
    .out_action (m_tuser),
    .no_line    (no_line),
    .div_run    (div_run),
    .out_busy   (out_busy)
  );

  `LPPS_ASSERT_NEXT(a_busy_after_accept, in_fire, !s_tready)
  `LPPS_ASSERT_IMP(a_no_overwrite, ctrl.op == lpps_pkg::OP_EMIT && m_tvalid && !m_tready, !status.in_fire)
  `LPPS_ASSERT_IMP(a_stop_zero_duty, m_tvalid && m_tuser == lpps_pkg::ACT_STOP, m_tdata == 16'd0)
  `LPPS_ASSERT_IMP(a_spin_equal_duty, m_tvalid && (m_tuser == lpps_pkg::ACT_SPIN_LEFT || m_tuser == lpps_pkg::ACT_SPIN_RIGHT), m_tdata[7:0] == m_tdata[15:8])

endmodule
